### hw/rtl/dtcf_pkg.sv
// Package for the binary64 to configurable float converter.
// Holds request and result structs, status codes and format constants; no dependencies.
package dtcf_pkg;

  localparam int unsigned SrcFracW = 52;
  localparam int unsigned SrcExpW  = 11;
  localparam int unsigned SrcBias  = 1023;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusOverflow  = 2'd1,
    StatusUnderflow = 2'd2,
    StatusNotFinite = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CfgExpBits  = 1'b0,
    CfgFracBits = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                in_sign;
    logic [SrcExpW-1:0]  in_exponent;
    logic [SrcFracW-1:0] in_fraction;
  } req_t;

  typedef struct packed {
    logic                out_sign;
    logic [SrcExpW-1:0]  out_exponent;
    logic [SrcFracW-1:0] out_fraction;
    logic [1:0]          status;
  } rsp_t;

  // Format data that travels with an item through the pipeline.
  typedef struct packed {
    logic [SrcExpW-1:0] ones;
    logic [SrcExpW-1:0] bias;
    logic [5:0]         fw;
    logic [5:0]         sh;
  } fmt_t;

endpackage

### hw/rtl/dtcf_round.sv
// Stages one and two: fraction alignment and round to nearest even.
// Depends on dtcf_pkg.
module dtcf_round (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  dtcf_pkg::req_t         req_i,
  input  dtcf_pkg::fmt_t         fmt_i,
  output logic                   valid_o,
  output dtcf_pkg::req_t         req_o,
  output dtcf_pkg::fmt_t         fmt_o,
  output logic [dtcf_pkg::SrcFracW:0] keep_o
);
  import dtcf_pkg::*;

  logic                valid1_q;
  req_t                req1_q;
  fmt_t                fmt1_q;
  logic [SrcFracW-1:0] keep1_q, keep1_d;
  logic                rnd1_q, rnd1_d;
  logic [SrcFracW-1:0] rem, half, mask;

  always_comb begin
    keep1_d = req_i.in_fraction >> fmt_i.sh;
    mask    = ~({SrcFracW{1'b1}} << fmt_i.sh);
    rem     = req_i.in_fraction & mask;
    half    = (fmt_i.sh == 6'd0) ? '0 : ({{(SrcFracW-1){1'b0}}, 1'b1} << (fmt_i.sh - 6'd1));
    rnd1_d  = (fmt_i.sh != 6'd0) && ((rem > half) || ((rem == half) && keep1_d[0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid_o  <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid_o  <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    req1_q  <= req_i;
    fmt1_q  <= fmt_i;
    keep1_q <= keep1_d;
    rnd1_q  <= rnd1_d;
    req_o   <= req1_q;
    fmt_o   <= fmt1_q;
    keep_o  <= {1'b0, keep1_q} + {{SrcFracW{1'b0}}, rnd1_q};
  end

endmodule

### hw/rtl/dtcf_pack.sv
// Stages three and four: exponent rebias, rounding carry, classification, range checks and packing.
// Depends on dtcf_pkg.
module dtcf_pack (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  dtcf_pkg::req_t              req_i,
  input  dtcf_pkg::fmt_t              fmt_i,
  input  logic [dtcf_pkg::SrcFracW:0] keep_i,
  output logic                        valid_o,
  output dtcf_pkg::rsp_t              rsp_o
);
  import dtcf_pkg::*;

  logic                valid3_q;
  req_t                req3_q;
  fmt_t                fmt3_q;
  logic [SrcFracW-1:0] keep3_q, keep3_d;
  logic signed [13:0]  biased3_q, biased3_d;
  logic                carry;
  rsp_t                rsp_d;

  always_comb begin
    carry     = (keep_i >> fmt_i.fw) != '0;
    keep3_d   = carry ? '0 : keep_i[SrcFracW-1:0];
    biased3_d = $signed({3'b000, req_i.in_exponent}) - 14'sd1023
              + $signed({3'b000, fmt_i.bias}) + (carry ? 14'sd1 : 14'sd0);
  end

  always_comb begin
    rsp_d.out_sign     = req3_q.in_sign;
    rsp_d.out_exponent = '0;
    rsp_d.out_fraction = '0;
    rsp_d.status       = StatusOk;
    if (req3_q.in_exponent == {SrcExpW{1'b1}}) begin
      rsp_d.out_exponent = fmt3_q.ones;
      rsp_d.status       = StatusNotFinite;
    end else if (req3_q.in_exponent == '0) begin
      rsp_d.status = (req3_q.in_fraction == '0) ? StatusOk : StatusUnderflow;
    end else if (biased3_q >= $signed({3'b000, fmt3_q.ones})) begin
      rsp_d.out_exponent = fmt3_q.ones;
      rsp_d.status       = StatusOverflow;
    end else if (biased3_q < 14'sd1) begin
      rsp_d.status = StatusUnderflow;
    end else begin
      rsp_d.out_exponent = biased3_q[SrcExpW-1:0];
      rsp_d.out_fraction = keep3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid_o  <= 1'b0;
    end else begin
      valid3_q <= valid_i;
      valid_o  <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    req3_q    <= req_i;
    fmt3_q    <= fmt_i;
    keep3_q   <= keep3_d;
    biased3_q <= biased3_d;
    rsp_o     <= rsp_d;
  end

endmodule

### hw/rtl/double_to_custom_float.sv
// Binary64 to configurable float converter, top level; uses dtcf_pkg, dtcf_round, dtcf_pack.
// One request is taken every cycle.
// busy is always low, since the four-stage pipeline never stalls.
// Reset clears the pipeline valid bits and sets exp_bits to 8 and frac_bits to 23.
module double_to_custom_float (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  dtcf_pkg::req_t req_i,
  input  logic           cfg_we_i,
  input  logic [0:0]     cfg_idx_i,
  input  logic [5:0]     cfg_data_i,
  output logic           valid_o,
  output dtcf_pkg::rsp_t rsp_o
);
  import dtcf_pkg::*;

  logic [3:0]         exp_bits_q;
  logic [5:0]         frac_bits_q;
  logic [3:0]         ew;
  logic [5:0]         fw;
  fmt_t               fmt;
  logic               v2;
  req_t               req2;
  fmt_t               fmt2;
  logic [SrcFracW:0]  keep2;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_bits_q  <= 4'd8;
      frac_bits_q <= 6'd23;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgExpBits) exp_bits_q <= cfg_data_i[3:0];
      else frac_bits_q <= cfg_data_i;
    end
  end

  always_comb begin
    ew       = (exp_bits_q < 4'd2) ? 4'd2 : (exp_bits_q > 4'd11) ? 4'd11 : exp_bits_q;
    fw       = (frac_bits_q > 6'd52) ? 6'd52 : frac_bits_q;
    fmt.ones = SrcExpW'(({12'd0} | (12'd1 << ew)) - 12'd1);
    fmt.bias = SrcExpW'((12'd1 << (ew - 4'd1)) - 12'd1);
    fmt.fw   = fw;
    fmt.sh   = 6'd52 - fw;
  end

  dtcf_round u_round (
    .clk_i, .rst_ni,
    .valid_i (start),
    .req_i   (req_i),
    .fmt_i   (fmt),
    .valid_o (v2),
    .req_o   (req2),
    .fmt_o   (fmt2),
    .keep_o  (keep2)
  );

  dtcf_pack u_pack (
    .clk_i, .rst_ni,
    .valid_i (v2),
    .req_i   (req2),
    .fmt_i   (fmt2),
    .keep_i  (keep2),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

endmodule

### bench/double_to_custom_float_chk.sv
// Checker for the binary64 to configurable float converter.
// Watches requests, configuration writes and results; depends on dtcf_pkg.
module double_to_custom_float_chk (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  dtcf_pkg::req_t req_i,
  input  logic           cfg_we_i,
  input  logic [0:0]     cfg_idx_i,
  input  logic [5:0]     cfg_data_i,
  input  logic           valid_i,
  input  dtcf_pkg::rsp_t rsp_i,
  output int             fail_count_o,
  output int             result_count_o,
  output int             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dtcf_pkg::*;

  logic [3:0] exp_width_q;
  logic [5:0] frac_width_q;
  rsp_t       converted_q[$];

  assign pending_o = converted_q.size();

  function automatic rsp_t convert_value(req_t r, logic [3:0] ew_cfg, logic [5:0] fw_cfg);
    rsp_t       o;
    int         ew;
    int         fw;
    int         sh;
    longint     ones;
    longint     bias;
    longint     biased;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    ew = ew_cfg;
    fw = fw_cfg;
    if (ew < 2) ew = 2;
    if (ew > 11) ew = 11;
    if (fw > 52) fw = 52;
    ones = (64'd1 << ew) - 1;
    bias = (64'd1 << (ew - 1)) - 1;
    o = '0;
    o.out_sign = r.in_sign;
    if (r.in_exponent == 11'h7ff) begin
      o.out_exponent = ones[10:0];
      o.status = StatusNotFinite;
      return o;
    end
    if (r.in_exponent == 0) begin
      o.status = (r.in_fraction == 0) ? StatusOk : StatusUnderflow;
      return o;
    end
    sh = 52 - fw;
    keep = {12'd0, r.in_fraction} >> sh;
    if (sh > 0) begin
      rem = {12'd0, r.in_fraction} & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep++;
    end
    biased = longint'(r.in_exponent) - 1023 + bias;
    if ((keep >> fw) != 0) begin
      keep = 0;
      biased++;
    end
    if (biased >= ones) begin
      o.out_exponent = ones[10:0];
      o.status = StatusOverflow;
    end else if (biased < 1) begin
      o.status = StatusUnderflow;
    end else begin
      o.out_exponent = biased[10:0];
      o.out_fraction = keep[51:0];
      o.status = StatusOk;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [65:0] got, logic [65:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      exp_width_q <= 4'd8;
      frac_width_q <= 6'd23;
      fail_count_o = 0;
      result_count_o <= 0;
      converted_q.delete();
    end else begin
      if (valid_i) begin
        result_count_o <= result_count_o + 1;
        if (converted_q.size() == 0) begin
          report_mismatch("unexpected result", 66'(rsp_i), 66'd0);
        end else begin
          want = converted_q.pop_front();
          if (rsp_i.out_sign !== want.out_sign)
            report_mismatch("sign", 66'(rsp_i.out_sign), 66'(want.out_sign));
          if (rsp_i.out_exponent !== want.out_exponent)
            report_mismatch("exponent", 66'(rsp_i.out_exponent), 66'(want.out_exponent));
          if (rsp_i.out_fraction !== want.out_fraction)
            report_mismatch("fraction", 66'(rsp_i.out_fraction), 66'(want.out_fraction));
          if (rsp_i.status !== want.status)
            report_mismatch("status", 66'(rsp_i.status), 66'(want.status));
        end
      end
      if (start_i && !busy_i) converted_q.push_back(convert_value(req_i, exp_width_q, frac_width_q));
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgExpBits) exp_width_q <= cfg_data_i[3:0];
        else frac_width_q <= cfg_data_i;
      end
    end
  end
endmodule

### bench/double_to_custom_float_tb.sv
// Testbench top for the binary64 to configurable float converter.
// Drives directed and random requests over several formats; uses dtcf_pkg and the checker.
module double_to_custom_float_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dtcf_pkg::*;

  localparam int WatchdogLimit = 2000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  req_t       req_i = '0;
  logic       cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = CfgExpBits;
  logic [5:0] cfg_data_i = '0;
  logic       valid_o;
  rsp_t       rsp_o;
  int         fail_count;
  int         result_count;
  int         pending;
  int         idle_pct;
  int         request_count = 0;
  int         quiet_cycles = 0;
  logic [3:0] cur_ew = 4'd8;
  logic [5:0] cur_fw = 6'd23;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  double_to_custom_float dut (.*);

  double_to_custom_float_chk chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .req_i, .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .valid_i(valid_o), .rsp_i(rsp_o), .fail_count_o(fail_count),
    .result_count_o(result_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_request(req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    request_count++;
    @(negedge clk_i);
  endtask

  task automatic write_format(logic [3:0] ew, logic [5:0] fw);
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgExpBits;
    cfg_data_i <= {2'b00, ew};
    @(negedge clk_i);
    cfg_idx_i <= CfgFracBits;
    cfg_data_i <= fw;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_ew = ew;
    cur_fw = fw;
  endtask

  function automatic req_t random_value(int ew, int fw);
    req_t   r;
    int     e;
    int     sh;
    int     bias;
    r.in_sign = 1'($urandom_range(1));
    r.in_fraction = SrcFracW'({$urandom, $urandom});
    if (ew < 2) ew = 2;
    if (ew > 11) ew = 11;
    if (fw > 52) fw = 52;
    bias = (1 << (ew - 1)) - 1;
    case ($urandom_range(9))
      0: r.in_exponent = SrcExpW'($urandom_range(2047));
      1: r.in_exponent = 11'h7ff;
      2: r.in_exponent = 0;
      default: begin
        e = 1023 - bias + $urandom_range(2 * bias + 2) - 1;
        if (e < 1) e = 1;
        if (e > 2046) e = 2046;
        r.in_exponent = SrcExpW'(e);
      end
    endcase
    sh = 52 - fw;
    if (sh > 0 && $urandom_range(3) == 0) begin
      // Force an exact tie or a near tie in the dropped bits.
      r.in_fraction &= ~((52'd1 << sh) - 1);
      r.in_fraction |= 52'd1 << (sh - 1);
      if ($urandom_range(1)) r.in_fraction |= 52'd1 << sh;
      if ($urandom_range(3) == 0) r.in_fraction |= 52'd1;
    end
    if ($urandom_range(15) == 0) r.in_fraction = '1;
    if (r.in_exponent == 0 && $urandom_range(1)) r.in_fraction = 0;
    return r;
  endfunction

  initial begin
    logic [3:0] ews[8] = '{4'd8, 4'd2, 4'd11, 4'd5, 4'd0, 4'd15, 4'd11, 4'd3};
    logic [5:0] fws[8] = '{6'd23, 6'd1, 6'd52, 6'd10, 6'd0, 6'd63, 6'd1, 6'd40};
    req_t r;
    idle_pct = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_request('{1'b0, 11'd0, 52'd0});
    send_request('{1'b1, 11'd0, 52'd0});
    send_request('{1'b0, 11'd0, 52'd1});
    send_request('{1'b1, 11'h7ff, '1});
    send_request('{1'b0, 11'h7ff, 52'd0});
    send_request('{1'b0, 11'd1023, 52'd0});
    send_request('{1'b1, 11'd1023, 52'h0000_0100_0000_0});
    send_request('{1'b0, 11'd1023, 52'h0000_0300_0000_0});
    send_request('{1'b0, 11'd1023, 52'h0000_0100_0000_1});
    send_request('{1'b0, 11'd1150, '1});
    send_request('{1'b0, 11'd1151, 52'd0});
    send_request('{1'b1, 11'd897, 52'd0});
    send_request('{1'b1, 11'd896, '1});
    send_request('{1'b0, 11'd1, 52'd0});
    send_request('{1'b0, 11'd2046, '1});
    for (int ph = 0; ph < 8; ph++) begin
      write_format(ews[ph], fws[ph]);
      for (int k = 0; k < 180; k++) begin
        case ((k / 45 + ph) % 4)
          0: idle_pct = 0;
          1: idle_pct = 54;
          2: idle_pct = 0;
          default: idle_pct = 13;
        endcase
        r = random_value(cur_ew, cur_fw);
        send_request(r);
      end
    end
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("Sent %0d requests under the reset format and eight written formats,",
             request_count);
    $display("including width extremes and out-of-range widths; %0d results checked.",
             result_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
